@@ design/stp_pkg.sv @@
package stp_pkg;

    localparam int SLOTS = 16;
    localparam int ID_W = 5;
    localparam int DELAY_W = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [ID_W-1:0] NONE_ID = (SLOTS < 32) ? ID_W'(SLOTS) : ID_W'(31);

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_CANCEL = 3'd2;
    localparam logic [2:0] ACT_POLL   = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    typedef logic [IDX_W-1:0] slot_idx_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [ID_W-1:0]    timer_id;
        logic [DELAY_W-1:0] delay_ticks;
    } req_t;

    typedef struct packed {
        logic            status;
        logic [ID_W-1:0] id_out;
        logic            expired;
    } rsp_t;

    // one decoded command, broadcast to every cell
    typedef struct packed {
        logic               tick;
        logic               start_id;
        logic               start_alloc;
        logic               cancel;
        logic               poll;
        logic               clear;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] delay;
    } cell_cmd_t;

    // signals rippling from cell to cell, lowest slot first
    typedef struct packed {
        logic      free_seen;
        logic      alloc;
        slot_idx_t alloc_idx;
        logic      sel_active;
        logic      sel_due;
    } chain_t;

endpackage

@@ design/stp_cell.sv @@
module stp_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  stp_pkg::slot_idx_t my_idx,
    input  stp_pkg::cell_cmd_t cmd,
    input  stp_pkg::chain_t    chain_in,
    output stp_pkg::chain_t    chain_out
);
    import stp_pkg::*;

    logic               active_reg;
    logic               active_next;
    logic [DELAY_W-1:0] target_reg;
    logic [DELAY_W-1:0] target_next;
    logic [DELAY_W-1:0] counter_reg;
    logic [DELAY_W-1:0] counter_next;
    logic               hit;
    logic               due;
    logic               take;

    assign hit = (cmd.id == ID_W'(my_idx));
    assign due = (target_reg <= counter_reg);
    // first free cell in the row takes an allocating start
    assign take = cmd.start_alloc && !active_reg && !chain_in.free_seen;

    always_comb
    begin
        chain_out = chain_in;
        chain_out.free_seen = chain_in.free_seen | ~active_reg;
        if (take)
        begin
            chain_out.alloc     = 1'b1;
            chain_out.alloc_idx = my_idx;
        end
        if (hit && active_reg)
        begin
            chain_out.sel_active = 1'b1;
            chain_out.sel_due    = due;
        end
    end

    always_comb
    begin
        active_next  = active_reg;
        target_next  = target_reg;
        counter_next = counter_reg;
        if (cmd.clear)
        begin
            active_next  = 1'b0;
            target_next  = '0;
            counter_next = '0;
        end
        else if (cmd.tick)
        begin
            if (active_reg)
            begin
                counter_next = counter_reg + DELAY_W'(1);
            end
        end
        else if ((cmd.start_id && hit) || take)
        begin
            target_next  = cmd.delay;
            counter_next = '0;
            if (take)
            begin
                active_next = 1'b1;
            end
        end
        else if ((cmd.cancel && hit) || (cmd.poll && hit && active_reg && due))
        begin
            active_next = 1'b0;
            target_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            target_reg  <= '0;
            counter_reg <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            target_reg  <= target_next;
            counter_reg <= counter_next;
        end
    end

endmodule

@@ design/software_timer_pool.sv @@
// Pool of one-shot timer slots, one cell per slot, all cells updated together.
// Every item (tick, start, cancel, poll, reset all) gives exactly one result item; items are
// taken back to back, one per cycle, and the result sits in an output register so a new
// item is taken while the previous result is waiting, stalling only when that register is
// full and stalled. A start with no slot id takes the lowest free slot, found by a free-slot
// chain rippling along the row of cells.
module software_timer_pool (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  stp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output stp_pkg::rsp_t rsp
);
    import stp_pkg::*;

    logic             fire;
    logic             is_slot;
    logic             full;
    logic             count_zero;
    cell_cmd_t        cmd;
    chain_t           chain [SLOTS+1];
    chain_t           last;
    rsp_t             result;
    logic             inc;
    logic             dec;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;

    assign req_stall  = rsp_valid_reg & rsp_stall;
    assign fire       = req_valid & ~req_stall;
    assign is_slot    = ({1'b0, req.timer_id} < (ID_W + 1)'(SLOTS));
    assign full       = (count_reg >= CNT_W'(SLOTS));
    assign count_zero = (count_reg == '0);

    always_comb
    begin
        cmd             = '0;
        cmd.id          = req.timer_id;
        cmd.delay       = req.delay_ticks;
        cmd.tick        = fire && (req.action == ACT_TICK);
        cmd.start_id    = fire && (req.action == ACT_START) && !full && is_slot;
        cmd.start_alloc = fire && (req.action == ACT_START) && !full && !is_slot;
        cmd.cancel      = fire && (req.action == ACT_CANCEL) && is_slot;
        cmd.poll        = fire && (req.action == ACT_POLL) && is_slot;
        cmd.clear       = fire && (req.action == ACT_CLEAR);
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        stp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_idx   (IDX_W'(i)),
            .cmd      (cmd),
            .chain_in (chain[i]),
            .chain_out(chain[i+1])
        );
    end

    assign last = chain[SLOTS];

    always_comb
    begin
        result         = '0;
        result.id_out  = NONE_ID;
        inc            = 1'b0;
        dec            = 1'b0;
        unique case (req.action)
            ACT_START:
            begin
                if (full)
                begin
                    result.status = 1'b1;
                    result.id_out = is_slot ? req.timer_id : NONE_ID;
                end
                else if (is_slot)
                begin
                    result.id_out = req.timer_id;
                end
                else if (last.alloc)
                begin
                    result.id_out = ID_W'(last.alloc_idx);
                    inc           = 1'b1;
                end
                else
                begin
                    result.status = 1'b1;
                end
            end
            ACT_CANCEL:
            begin
                if (is_slot)
                begin
                    result.status = count_zero;
                    dec           = !count_zero;
                end
            end
            ACT_POLL:
            begin
                if (last.sel_active)
                begin
                    if (last.sel_due)
                    begin
                        result.status  = count_zero;
                        result.expired = !count_zero;
                        dec            = !count_zero;
                    end
                    else
                    begin
                        result.id_out = req.timer_id;
                    end
                end
                else
                begin
                    result.expired = 1'b1;
                    result.id_out  = is_slot ? req.timer_id : NONE_ID;
                end
            end
            default:
            begin
                // tick, reset all and unused codes report ok with no slot
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            if (req.action == ACT_CLEAR)
            begin
                count_next = '0;
            end
            else if (inc)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (dec)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ tb/sv/software_timer_pool_tb.sv @@
module software_timer_pool_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import stp_pkg::*;

    localparam logic [2:0]      ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0]      ACT_SPARE_LAST  = 3'd7;
    localparam logic [ID_W-1:0] ID_TOP          = '1;
    localparam int              CYCLE_LIMIT     = 1_000_000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // predicted pool state
    logic [SLOTS-1:0]   timer_mask;
    int                 live_count;
    logic [DELAY_W-1:0] slot_goal  [SLOTS];
    logic [DELAY_W-1:0] slot_ticks [SLOTS];

    rsp_t pending_rsp [$];
    rsp_t want_rsp;
    int   error_count    = 0;
    int   cycle_count    = 0;
    bit   sender_idle_en = 1'b1;
    bit   sink_stall_en  = 1'b1;

    software_timer_pool dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_rsp.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void clear_pool();
        timer_mask = '0;
        live_count = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_goal[i]  = '0;
            slot_ticks[i] = '0;
        end
    endfunction

    // frees a slot; returns 1 when the active count was already zero
    function automatic logic drop_slot(input int s);
        timer_mask[s] = 1'b0;
        slot_goal[s]  = '0;
        if (live_count > 0)
        begin
            live_count--;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic rsp_t pool_predict(input req_t r);
        rsp_t o;
        int   s;
        int   free_slot;
        logic named;
        o        = '0;
        o.id_out = NONE_ID;
        named    = (r.timer_id < SLOTS);
        s        = int'(r.timer_id);
        case (r.action)
            ACT_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (timer_mask[i])
                        slot_ticks[i] = slot_ticks[i] + 1'b1;
            end
            ACT_START:
            begin
                if (live_count >= SLOTS)
                begin
                    o.status = 1'b1;
                    if (named)
                        o.id_out = r.timer_id;
                end
                else if (named)
                begin
                    // reload only, the active bit stays as it is
                    slot_goal[s]  = r.delay_ticks;
                    slot_ticks[s] = '0;
                    o.id_out      = r.timer_id;
                end
                else
                begin
                    free_slot = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!timer_mask[i])
                            free_slot = i;
                    if (free_slot < 0)
                        o.status = 1'b1;
                    else
                    begin
                        slot_goal[free_slot]  = r.delay_ticks;
                        slot_ticks[free_slot] = '0;
                        timer_mask[free_slot] = 1'b1;
                        live_count++;
                        o.id_out = ID_W'(free_slot);
                    end
                end
            end
            ACT_CANCEL:
            begin
                if (named)
                    o.status = drop_slot(s);
            end
            ACT_POLL:
            begin
                if (named && timer_mask[s])
                begin
                    if (slot_goal[s] <= slot_ticks[s])
                    begin
                        o.status  = drop_slot(s);
                        o.expired = !o.status;
                    end
                    else
                        o.id_out = r.timer_id;
                end
                else
                begin
                    o.expired = 1'b1;
                    if (named)
                        o.id_out = r.timer_id;
                end
            end
            ACT_CLEAR:
                clear_pool();
            default: ;
        endcase
        return o;
    endfunction

    task automatic send_item(input logic [2:0] act, input logic [ID_W-1:0] id,
                             input logic [DELAY_W-1:0] dly);
        req_t r;
        r.action      = act;
        r.timer_id    = id;
        r.delay_ticks = dly;
        if (sender_idle_en && $urandom_range(0, 99) < 15)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        pending_rsp.push_back(pool_predict(r));
    endtask

    // result side back-pressure in random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_stall_en && $urandom_range(0, 99) < 12)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    function automatic void compare_field(input string name, input logic [ID_W-1:0] want_v,
                                          input logic [ID_W-1:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %p", $time, rsp);
                error_count++;
            end
            else
            begin
                want_rsp = pending_rsp.pop_front();
                compare_field("status", ID_W'(want_rsp.status), ID_W'(rsp.status));
                compare_field("id_out", want_rsp.id_out, rsp.id_out);
                compare_field("expired", ID_W'(want_rsp.expired), ID_W'(rsp.expired));
            end
        end
    end

    task automatic test_basic_actions();
        send_item(ACT_TICK, NONE_ID, '1);
        send_item(ACT_START, NONE_ID, '0);
        send_item(ACT_POLL, 5'd0, '0);
        send_item(ACT_POLL, 5'd0, '0);
        send_item(ACT_POLL, NONE_ID, '0);
        send_item(ACT_POLL, ID_TOP, '0);
        send_item(ACT_START, NONE_ID, 16'd2);
        send_item(ACT_START, ID_TOP, '1);
        send_item(ACT_TICK, 5'd0, '0);
        send_item(ACT_POLL, 5'd0, '0);
        send_item(ACT_TICK, 5'd0, '0);
        send_item(ACT_POLL, 5'd0, '0);
        // reload of a slot that is not running leaves it idle
        send_item(ACT_START, 5'd15, 16'h8000);
        send_item(ACT_POLL, 5'd15, '0);
        send_item(ACT_CANCEL, NONE_ID, '0);
        send_item(ACT_CANCEL, 5'd1, '0);
        send_item(ACT_CANCEL, 5'd1, '0);
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
            send_item(3'(a), 5'd10, 16'h5555);
        send_item(ACT_CLEAR, 5'd0, '1);
    endtask

    task automatic test_pool_exhaustion();
        send_item(ACT_CLEAR, NONE_ID, '0);
        repeat (SLOTS) send_item(ACT_START, NONE_ID, DELAY_W'($urandom));
        send_item(ACT_START, NONE_ID, 16'd1);
        send_item(ACT_START, 5'd3, 16'd1);
        send_item(ACT_START, ID_TOP, 16'd1);
        // a second cancel of the same slot leaves the count below the mask
        send_item(ACT_CANCEL, 5'd0, '0);
        send_item(ACT_CANCEL, 5'd0, '0);
        send_item(ACT_START, NONE_ID, '0);
        send_item(ACT_START, NONE_ID, '0);
        send_item(ACT_START, 5'd7, '0);
        send_item(ACT_POLL, 5'd7, '0);
        send_item(ACT_POLL, 5'd0, '0);
    endtask

    task automatic test_count_drift();
        send_item(ACT_CLEAR, NONE_ID, '0);
        send_item(ACT_START, NONE_ID, '0);
        send_item(ACT_CANCEL, 5'd9, '0);
        // slot still active with a zero count: poll fails its cancel
        send_item(ACT_POLL, 5'd0, '0);
        send_item(ACT_POLL, 5'd0, '0);
        send_item(ACT_START, NONE_ID, '0);
        send_item(ACT_CANCEL, 5'd0, '0);
        send_item(ACT_CANCEL, 5'd0, '0);
    endtask

    task automatic test_long_delay();
        send_item(ACT_CLEAR, NONE_ID, '0);
        send_item(ACT_START, NONE_ID, '1);
        send_item(ACT_START, NONE_ID, 16'd40);
        repeat (39) send_item(ACT_TICK, NONE_ID, '0);
        send_item(ACT_POLL, 5'd1, '0);
        send_item(ACT_TICK, NONE_ID, '0);
        send_item(ACT_POLL, 5'd1, '0);
        // slot 0 with the largest target is still far from due
        send_item(ACT_POLL, 5'd0, '0);
        send_item(ACT_START, 5'd0, 16'd3);
        repeat (3) send_item(ACT_TICK, NONE_ID, '0);
        send_item(ACT_POLL, 5'd0, '0);
        send_item(ACT_CLEAR, NONE_ID, '0);
    endtask

    task automatic test_random_traffic(input int n_items, input bit allow_idle);
        int                 done;
        int                 start_pct;
        int                 pick;
        int                 sel;
        int                 s;
        logic [2:0]         act;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] dly;
        done = 0;
        while (done < n_items)
        begin
            start_pct      = $urandom_range(10, 50);
            sender_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            sink_stall_en  = allow_idle && ($urandom_range(0, 3) != 0);
            repeat (50)
            begin
                pick = $urandom_range(0, 99);
                if (pick < start_pct)
                    act = ACT_START;
                else if (pick < start_pct + 30)
                    act = ACT_TICK;
                else if (pick < start_pct + 38)
                    act = ACT_CANCEL;
                else if (pick < 98)
                    act = ACT_POLL;
                else if (pick == 98)
                    act = ACT_CLEAR;
                else
                    act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));

                sel = $urandom_range(0, 9);
                if (act == ACT_START)
                begin
                    if (sel < 7)
                        id = NONE_ID;
                    else if (sel < 9)
                        id = ID_W'($urandom_range(0, SLOTS - 1));
                    else
                        id = ID_W'($urandom_range(SLOTS, 31));
                end
                else if (act == ACT_POLL && timer_mask != '0 && sel < 6)
                begin
                    // mostly poll a slot that is running
                    s = $urandom_range(0, SLOTS - 1);
                    while (!timer_mask[s])
                        s = (s + 1) % SLOTS;
                    id = ID_W'(s);
                end
                else if (sel < 8)
                    id = ID_W'($urandom_range(0, SLOTS - 1));
                else
                    id = ID_W'($urandom_range(SLOTS, 31));

                sel = $urandom_range(0, 9);
                if (sel < 6)
                    dly = DELAY_W'($urandom_range(0, 15));
                else if (sel < 9)
                    dly = DELAY_W'($urandom_range(0, 255));
                else
                    dly = DELAY_W'($urandom);

                send_item(act, id, dly);
                done++;
            end
        end
    endtask

    initial
    begin
        clear_pool();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_actions();
        test_pool_exhaustion();
        test_count_drift();
        test_long_delay();
        test_random_traffic(1500, 1'b1);
        test_random_traffic(250, 1'b0);

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
design/stp_pkg.sv
design/stp_cell.sv
design/software_timer_pool.sv
tb/sv/software_timer_pool_tb.sv
